### design/fssm_pkg.sv
// ----------------------------------------------------------------------------
// fssm_pkg
// Types and constants shared by the fieldbus slave state machine modules.
// ----------------------------------------------------------------------------
package fssm_pkg;

  localparam int REQ_W      = 8;
  localparam int STATE_W    = 4;
  localparam int LEN_W      = 16;
  localparam int VAL_W      = 16;
  localparam int REASON_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEN_W-1:0] EXP_OUT_LEN_RST = LEN_W'(2);
  localparam logic [LEN_W-1:0] EXP_IN_LEN_RST  = LEN_W'(6);

  typedef enum logic [STATE_W-1:0] {
    ST_INIT   = 4'b0001,
    ST_PREOP  = 4'b0010,
    ST_SAFEOP = 4'b0100,
    ST_OP     = 4'b1000
  } state_t;

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE    = 2'd0,
    RSN_OUT_CFG = 2'd1,
    RSN_IN_CFG  = 2'd2
  } reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXP_OUT_LEN = 2'd0,
    REG_EXP_IN_LEN  = 2'd1
  } reg_idx_t;

  typedef struct packed {
    logic [REQ_W-1:0] requested_state;
    logic             control_read_ok;
    logic             sync_read_ok;
    logic [LEN_W-1:0] output_sm_length;
    logic [LEN_W-1:0] input_sm_length;
    logic             target_read_ok;
    logic [VAL_W-1:0] target_value;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0] exp_out_len;
    logic [LEN_W-1:0] exp_in_len;
  } cfg_t;

  typedef struct packed {
    logic [STATE_W-1:0]  status_state;
    logic                status_error;
    logic [REASON_W-1:0] refusal_reason;
    logic                apply_strobe;
    logic [VAL_W-1:0]    applied_value;
    logic                echo_valid;
    logic [VAL_W-1:0]    echo_value;
  } result_t;

endpackage

### design/fssm_cfg.sv
// ----------------------------------------------------------------------------
// fssm_cfg
// Configuration registers: expected sync manager lengths.
// ----------------------------------------------------------------------------
module fssm_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [fssm_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [fssm_pkg::CFG_DATA_W-1:0]   wr_data,
  output fssm_pkg::cfg_t                    cfg
);
  import fssm_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.exp_out_len <= EXP_OUT_LEN_RST;
      regs.exp_in_len  <= EXP_IN_LEN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_EXP_OUT_LEN: regs.exp_out_len <= wr_data[LEN_W-1:0];
        REG_EXP_IN_LEN:  regs.exp_in_len  <= wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### design/fssm_core.sv
// ----------------------------------------------------------------------------
// fssm_core
// State registers and per-poll transition, apply and echo logic.
// ----------------------------------------------------------------------------
module fssm_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  fssm_pkg::item_t   item,
  input  fssm_pkg::cfg_t    cfg,
  output fssm_pkg::result_t res
);
  import fssm_pkg::*;

  state_t           current_state, current_state_next;
  logic             error_shown, error_shown_next;
  logic [VAL_W-1:0] last_value, last_value_next;
  logic             value_applied, value_applied_next;

  logic [STATE_W-1:0] req;
  reason_t            reason;
  logic               strobe;
  logic               echo;

  assign req = item.requested_state[STATE_W-1:0];

  always_comb begin
    current_state_next = current_state;
    error_shown_next   = error_shown;
    last_value_next    = last_value;
    value_applied_next = value_applied;
    reason             = RSN_NONE;
    strobe             = 1'b0;
    echo               = 1'b0;

    if (item.control_read_ok) begin
      if (req != current_state) begin
        unique case (req)
          ST_INIT, ST_PREOP: begin
            current_state_next = state_t'(req);
            error_shown_next   = 1'b0;
            value_applied_next = 1'b0;
          end
          ST_SAFEOP: begin
            if (item.sync_read_ok) begin
              if (item.output_sm_length != cfg.exp_out_len) begin
                reason           = RSN_OUT_CFG;
                error_shown_next = 1'b1;
              end else if (item.input_sm_length != cfg.exp_in_len) begin
                reason           = RSN_IN_CFG;
                error_shown_next = 1'b1;
              end else begin
                current_state_next = ST_SAFEOP;
                error_shown_next   = 1'b0;
                value_applied_next = 1'b0;
              end
            end
          end
          ST_OP: begin
            if (current_state == ST_SAFEOP) begin
              current_state_next = ST_OP;
              error_shown_next   = 1'b0;
            end else begin
              reason           = RSN_OUT_CFG;
              error_shown_next = 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (current_state_next == ST_SAFEOP || current_state_next == ST_OP) begin
        echo = 1'b1;
        if (item.target_read_ok && current_state_next == ST_OP &&
            (!value_applied_next || item.target_value != last_value)) begin
          strobe             = 1'b1;
          last_value_next    = item.target_value;
          value_applied_next = 1'b1;
        end
      end
    end

    res.status_state   = current_state_next;
    res.status_error   = error_shown_next;
    res.refusal_reason = reason;
    res.apply_strobe   = strobe;
    res.applied_value  = strobe ? item.target_value : '0;
    res.echo_valid     = echo;
    res.echo_value     = echo ? last_value_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_state <= ST_INIT;
      error_shown   <= 1'b0;
      last_value    <= '0;
      value_applied <= 1'b0;
    end else if (fire) begin
      current_state <= current_state_next;
      error_shown   <= error_shown_next;
      last_value    <= last_value_next;
      value_applied <= value_applied_next;
    end
  end

endmodule

### design/fssm_outreg.sv
// ----------------------------------------------------------------------------
// fssm_outreg
// Result register with valid flag, held until taken downstream.
// ----------------------------------------------------------------------------
module fssm_outreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  fssm_pkg::result_t din,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              can_load,
  output fssm_pkg::result_t dout
);
  import fssm_pkg::*;

  logic    vld;
  result_t data;

  assign can_load = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (can_load) begin
      vld <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= din;
    end
  end

  assign out_valid = vld;
  assign dout      = data;

endmodule

### design/fieldbus_slave_state_machine_top.sv
// ----------------------------------------------------------------------------
// fieldbus_slave_state_machine_top
// Application-layer state machine of a fieldbus slave, one poll per item.
//
// Channel   Handshake              Payload
// in        in_valid / in_ready    requested_state .. target_value
// out       out_valid / out_ready  status_state .. echo_value
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; a result passes
// through the input register, then the result register, before it is shown.
// The state update happens as the item leaves the input register. Reset
// clears state to INIT and the lengths to 2 and 6. A stalled output holds
// both stages; cfg_ready is always high.
// ----------------------------------------------------------------------------
module fieldbus_slave_state_machine_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fssm_pkg::REQ_W-1:0]          requested_state,
  input  logic                                control_read_ok,
  input  logic                                sync_read_ok,
  input  logic [fssm_pkg::LEN_W-1:0]          output_sm_length,
  input  logic [fssm_pkg::LEN_W-1:0]          input_sm_length,
  input  logic                                target_read_ok,
  input  logic [fssm_pkg::VAL_W-1:0]          target_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fssm_pkg::STATE_W-1:0]        status_state,
  output logic                                status_error,
  output logic [fssm_pkg::REASON_W-1:0]       refusal_reason,
  output logic                                apply_strobe,
  output logic [fssm_pkg::VAL_W-1:0]          applied_value,
  output logic                                echo_valid,
  output logic [fssm_pkg::VAL_W-1:0]          echo_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fssm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fssm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fssm_pkg::*;

  item_t   in_q;
  logic    in_vld;
  logic    can_load;
  logic    fire;
  cfg_t    cfg;
  result_t res;
  result_t res_q;

  assign cfg_ready = 1'b1;
  assign fire      = in_vld && can_load;
  assign in_ready  = !in_vld || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q.requested_state  <= requested_state;
      in_q.control_read_ok  <= control_read_ok;
      in_q.sync_read_ok     <= sync_read_ok;
      in_q.output_sm_length <= output_sm_length;
      in_q.input_sm_length  <= input_sm_length;
      in_q.target_read_ok   <= target_read_ok;
      in_q.target_value     <= target_value;
    end
  end

  fssm_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fssm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_q),
    .cfg  (cfg),
    .res  (res)
  );

  fssm_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .din       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .dout      (res_q)
  );

  assign status_state   = res_q.status_state;
  assign status_error   = res_q.status_error;
  assign refusal_reason = res_q.refusal_reason;
  assign apply_strobe   = res_q.apply_strobe;
  assign applied_value  = res_q.applied_value;
  assign echo_valid     = res_q.echo_valid;
  assign echo_value     = res_q.echo_value;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(status_state))
    else $error("status state not one-hot");

  a_refusal_sets_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && refusal_reason != RSN_NONE) |-> status_error)
    else $error("refusal without error bit");

  a_strobe_in_op: assert property (@(posedge clk) disable iff (rst)
    (out_valid && apply_strobe) |->
      (status_state == ST_OP && echo_valid && echo_value == applied_value))
    else $error("apply outside OP or echo mismatch");

  a_no_echo_in_low_states: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status_state == ST_INIT || status_state == ST_PREOP)) |->
      (!echo_valid && !apply_strobe))
    else $error("echo or apply in INIT or PREOP");
`endif

endmodule
